// ===== design/hccu_pkg.sv =====
// shared types, constants and keyword tables for the connection header classifier
package hccu_pkg;

    // one input beat as it travels inside the block
    typedef struct packed {
        logic [7:0] header_byte;
        logic       last;
        logic       no_value;
        logic       is_http_1_0;
    } hccu_item_t;

    // one result beat
    typedef struct packed {
        logic header_error;
        logic saw_close;
        logic saw_keep_alive;
        logic saw_upgrade;
        logic should_close;
    } hccu_result_t;

    // keyword indexes, also bit positions in candidate and found masks
    localparam int KW_NUM = 3;
    localparam logic [1:0] KW_CLOSE      = 2'd0;
    localparam logic [1:0] KW_KEEP_ALIVE = 2'd1;
    localparam logic [1:0] KW_UPGRADE    = 2'd2;

    localparam int POS_W = 4;
    localparam logic [POS_W-1:0] POS_MAX = 4'd15;

    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_UC_A  = 8'h41;
    localparam logic [7:0] CHAR_UC_Z  = 8'h5A;
    localparam logic [7:0] CASE_FOLD  = 8'h20;

    // keyword length in bytes
    function automatic logic [POS_W-1:0] kw_len(input logic [1:0] kw);
        logic [POS_W-1:0] len;
        unique case (kw)
            KW_CLOSE:      len = 4'd5;
            KW_KEEP_ALIVE: len = 4'd10;
            KW_UPGRADE:    len = 4'd7;
            default:       len = 4'd0;
        endcase
        return len;
    endfunction

    // lower-case keyword text, zero past the end
    function automatic logic [7:0] kw_char(input logic [1:0] kw, input logic [POS_W-1:0] pos);
        logic [7:0] ch;
        ch = 8'h00;
        unique case (kw)
            KW_CLOSE: begin
                unique case (pos)
                    4'd0: ch = "c";
                    4'd1: ch = "l";
                    4'd2: ch = "o";
                    4'd3: ch = "s";
                    4'd4: ch = "e";
                    default: ch = 8'h00;
                endcase
            end
            KW_KEEP_ALIVE: begin
                unique case (pos)
                    4'd0: ch = "k";
                    4'd1: ch = "e";
                    4'd2: ch = "e";
                    4'd3: ch = "p";
                    4'd4: ch = "-";
                    4'd5: ch = "a";
                    4'd6: ch = "l";
                    4'd7: ch = "i";
                    4'd8: ch = "v";
                    4'd9: ch = "e";
                    default: ch = 8'h00;
                endcase
            end
            KW_UPGRADE: begin
                unique case (pos)
                    4'd0: ch = "u";
                    4'd1: ch = "p";
                    4'd2: ch = "g";
                    4'd3: ch = "r";
                    4'd4: ch = "a";
                    4'd5: ch = "d";
                    4'd6: ch = "e";
                    default: ch = 8'h00;
                endcase
            end
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

// ===== design/hccu_parse.sv =====
// token matching state and per-beat update, result on the last beat
module hccu_parse import hccu_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         step,
    input  hccu_item_t   item,
    output logic         result_valid,
    output hccu_result_t result
);

    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [KW_NUM-1:0] cand_reg, cand_next;
    logic              seg_reg, seg_next;
    logic              started_reg, started_next;
    logic              ended_reg, ended_next;
    logic [KW_NUM-1:0] found_reg, found_next;
    logic              err_reg, err_next;

    logic              byte_in;
    logic              is_comma;
    logic              is_blank;
    logic [7:0]        lower;
    logic              end_seg;
    logic [KW_NUM-1:0] hit;

    assign byte_in  = !item.no_value;
    assign is_comma = (item.header_byte == CHAR_COMMA);
    assign is_blank = (item.header_byte == CHAR_SPACE) || (item.header_byte == CHAR_TAB);
    assign lower    = ((item.header_byte >= CHAR_UC_A) && (item.header_byte <= CHAR_UC_Z))
                    ? (item.header_byte + CASE_FOLD) : item.header_byte;

    // byte update, segment close and end of header
    always_comb begin
        pos_next     = pos_reg;
        cand_next    = cand_reg;
        seg_next     = seg_reg;
        started_next = started_reg;
        ended_next   = ended_reg;
        found_next   = found_reg;
        err_next     = err_reg;
        hit          = '0;

        // advance the matcher on a non-comma byte
        if (byte_in && !is_comma) begin
            seg_next = 1'b1;
            if (is_blank) begin
                ended_next = ended_reg | started_reg;
            end else begin
                if (ended_reg) begin
                    cand_next = '0;
                end
                started_next = 1'b1;
                for (int k = 0; k < KW_NUM; k++) begin
                    if (cand_next[k] && ((pos_reg >= kw_len(2'(k))) ||
                                         (kw_char(2'(k), pos_reg) != lower))) begin
                        cand_next[k] = 1'b0;
                    end
                end
                if (pos_reg != POS_MAX) begin
                    pos_next = pos_reg + 4'd1;
                end
            end
        end

        // close the segment on a comma or at the end of a nonempty tail
        end_seg = (byte_in && is_comma) || (item.last && seg_next);
        for (int k = 0; k < KW_NUM; k++) begin
            hit[k] = cand_next[k] && (pos_next == kw_len(2'(k)));
        end
        if (end_seg) begin
            if (!started_next || (hit == '0)) begin
                err_next = 1'b1;
            end else if (hit[KW_CLOSE] && found_reg[KW_KEEP_ALIVE]) begin
                err_next = 1'b1;
            end else if (hit[KW_KEEP_ALIVE] && found_reg[KW_CLOSE]) begin
                err_next = 1'b1;
            end else begin
                found_next = found_reg | hit;
            end
            pos_next     = '0;
            cand_next    = '1;
            seg_next     = 1'b0;
            started_next = 1'b0;
            ended_next   = 1'b0;
        end

        // result from the final flags
        result_valid = item.last;
        if (err_next) begin
            result = '{header_error: 1'b1, saw_close: 1'b0, saw_keep_alive: 1'b0,
                       saw_upgrade: 1'b0, should_close: 1'b1};
        end else begin
            result.header_error   = 1'b0;
            result.saw_close      = found_next[KW_CLOSE];
            result.saw_keep_alive = found_next[KW_KEEP_ALIVE];
            result.saw_upgrade    = found_next[KW_UPGRADE];
            result.should_close   = (found_next == '0) ? item.is_http_1_0
                                                       : found_next[KW_CLOSE];
        end

        // header done, start over
        if (item.last) begin
            found_next = '0;
            err_next   = 1'b0;
        end
    end

    // matcher state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            cand_reg    <= '1;
            seg_reg     <= 1'b0;
            started_reg <= 1'b0;
            ended_reg   <= 1'b0;
            found_reg   <= '0;
            err_reg     <= 1'b0;
        end else if (step) begin
            pos_reg     <= pos_next;
            cand_reg    <= cand_next;
            seg_reg     <= seg_next;
            started_reg <= started_next;
            ended_reg   <= ended_next;
            found_reg   <= found_next;
            err_reg     <= err_next;
        end
    end

`ifndef NO_ASSERTIONS
    // state is back to reset after the final beat
    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        step && item.last |=> (pos_reg == '0) && (found_reg == '0) && !err_reg && !seg_reg)
        else $error("state not cleared after last beat");

    // close and keep-alive never recorded together
    a_no_conflict: assert property (@(posedge aclk) disable iff (!aresetn)
        !(found_reg[KW_CLOSE] && found_reg[KW_KEEP_ALIVE]))
        else $error("close and keep-alive both found");

    // a token cannot start before the segment holds a byte
    a_started_in_seg: assert property (@(posedge aclk) disable iff (!aresetn)
        started_reg |-> seg_reg)
        else $error("token started in empty segment");
`endif

endmodule

// ===== design/http_connection_header_classifier_unit.sv =====
// Connection header classifier top level: input register, matcher, result register.
// A result beat goes from the input register through the matcher into the result register.
// Throughput: one input beat per cycle; the matcher updates once per beat.
// The input register moves on unless a result must wait for a stalled output.
// Reset: aresetn synchronous, active low; clears valids and all matcher state.
module http_connection_header_classifier_unit import hccu_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // header_byte[7:0], is_http_1_0[8], zero fill
    input  logic        s_axis_tlast,
    input  logic        s_axis_tuser,  // no_value
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata   // header_error, saw_close, saw_keep_alive,
                                       // saw_upgrade, should_close, zero fill
);

    logic         in_valid_reg;
    hccu_item_t   in_item_reg;
    logic         out_valid_reg;
    hccu_result_t out_result_reg;

    logic         step;
    logic         result_valid;
    hccu_result_t result;

    // the held beat moves on when it makes no result or the output slot frees
    assign step          = in_valid_reg && (!in_item_reg.last || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || step;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_item_reg.header_byte <= s_axis_tdata[7:0];
            in_item_reg.is_http_1_0 <= s_axis_tdata[8];
            in_item_reg.last        <= s_axis_tlast;
            in_item_reg.no_value    <= s_axis_tuser;
        end
    end

    hccu_parse u_parse (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (step),
        .item         (in_item_reg),
        .result_valid (result_valid),
        .result       (result)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step && result_valid) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && result_valid) begin
            out_result_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000,
                            out_result_reg.should_close,
                            out_result_reg.saw_upgrade,
                            out_result_reg.saw_keep_alive,
                            out_result_reg.saw_close,
                            out_result_reg.header_error};

`ifndef NO_ASSERTIONS
    // an error beat carries no keyword flags and closes
    a_error_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_result_reg.header_error |->
            !out_result_reg.saw_close && !out_result_reg.saw_keep_alive &&
            !out_result_reg.saw_upgrade && out_result_reg.should_close)
        else $error("error result carries flags");

    // close always leads to should_close
    a_close_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_result_reg.saw_close |-> out_result_reg.should_close)
        else $error("close without should_close");

    // a result beat cannot be overwritten while stalled
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_axis_tready |-> !(step && result_valid))
        else $error("stalled result overwritten");

    // input side stalls only behind a held beat
    a_stall_reason: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |-> in_valid_reg && in_item_reg.last && out_valid_reg)
        else $error("unexpected input stall");
`endif

endmodule

// ===== sim/http_connection_header_classifier_unit_tb.sv =====
// testbench for the connection header classifier: directed and random header values, self-checked
`timescale 1ns / 1ps

module http_connection_header_classifier_unit_tb;
    import hccu_pkg::*;

    localparam int RANDOM_BEATS = 800;
    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_EVERY  = 300;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;  // header_byte[7:0], is_http_1_0[8], zero fill
    logic        s_axis_tlast  = 1'b0;
    logic        s_axis_tuser  = 1'b0;  // no_value
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;  // header_error, saw_close, saw_keep_alive,
                                // saw_upgrade, should_close, zero fill

    http_connection_header_classifier_unit i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 aclk = ~aclk;

    // keyword spellings, indexed like the package keyword codes
    string kw_word [KW_NUM] = '{"close", "keep-alive", "upgrade"};

    // classifier state mirrored by the testbench
    logic [POS_W-1:0]  match_pos;
    logic [KW_NUM-1:0] live_kw;
    logic [KW_NUM-1:0] found_kw;
    bit                seg_nonempty;
    bit                tok_started;
    bit                tok_ended;
    bit                err_sticky;

    hccu_result_t verdict_q [$];
    int           mismatch_count = 0;
    int           payload_beats  = 0;
    int           quiet_cycles   = 0;
    int           rx_hold        = 0;
    bit           calm           = 1'b0;

    // start a fresh comma-separated segment
    function automatic void clear_segment();
        match_pos    = '0;
        live_kw      = '1;
        seg_nonempty = 1'b0;
        tok_started  = 1'b0;
        tok_ended    = 1'b0;
    endfunction

    // close the current segment and fold its keyword into the found set
    function automatic void finish_token();
        logic [KW_NUM-1:0] hit;
        hit = '0;
        if (!tok_started) begin
            err_sticky = 1'b1;
        end else begin
            for (int k = 0; k < KW_NUM; k++)
                if (live_kw[k] && match_pos == kw_word[k].len())
                    hit = KW_NUM'(1) << k;
            if (hit == '0)
                err_sticky = 1'b1;
            else if (hit[KW_CLOSE] && found_kw[KW_KEEP_ALIVE])
                err_sticky = 1'b1;
            else if (hit[KW_KEEP_ALIVE] && found_kw[KW_CLOSE])
                err_sticky = 1'b1;
            else
                found_kw = found_kw | hit;
        end
        clear_segment();
    endfunction

    // run one header byte through the keyword matcher
    function automatic void absorb_byte(input logic [7:0] b);
        logic [7:0] ch;
        int pos;
        if (b == CHAR_COMMA) begin
            finish_token();
            return;
        end
        seg_nonempty = 1'b1;
        if (b == CHAR_SPACE || b == CHAR_TAB) begin
            if (tok_started)
                tok_ended = 1'b1;
            return;
        end
        if (tok_ended)
            live_kw = '0;
        tok_started = 1'b1;
        ch = (b >= CHAR_UC_A && b <= CHAR_UC_Z) ? b + CASE_FOLD : b;
        pos = int'(match_pos);
        for (int k = 0; k < KW_NUM; k++)
            if (live_kw[k] && (pos >= kw_word[k].len() || 8'(kw_word[k][pos]) != ch))
                live_kw[k] = 1'b0;
        if (match_pos < POS_MAX)
            match_pos = match_pos + 1'b1;
    endfunction

    // expected verdict for one accepted beat; returns 1 when a result is due
    function automatic bit classify_beat(input logic [7:0] b, input bit lst, input bit nv,
                                         input bit v10, output hccu_result_t res);
        res = '0;
        if (!nv)
            absorb_byte(b);
        if (!lst)
            return 1'b0;
        if (seg_nonempty)
            finish_token();
        if (err_sticky) begin
            res.header_error = 1'b1;
            res.should_close = 1'b1;
        end else begin
            res.saw_close      = found_kw[KW_CLOSE];
            res.saw_keep_alive = found_kw[KW_KEEP_ALIVE];
            res.saw_upgrade    = found_kw[KW_UPGRADE];
            res.should_close   = (found_kw == '0) ? v10 : found_kw[KW_CLOSE];
        end
        clear_segment();
        found_kw   = '0;
        err_sticky = 1'b0;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns: mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // send one beat after a random gap and predict its verdict
    task automatic send_beat(input logic [7:0] b, input bit lst, input bit nv, input bit v10);
        int gap;
        hccu_result_t res;
        gap = calm ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'b0, v10, b};
        s_axis_tlast  <= lst;
        s_axis_tuser  <= nv;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        if (classify_beat(b, lst, nv, v10, res))
            verdict_q.push_back(res);
        if (!(nv && !lst))
            payload_beats++;
    endtask

    // send a header value; ignored no-value beats are sprinkled in
    task automatic send_header(ref logic [7:0] q [$], input bit v10, input bit nv_tail);
        bit at_end;
        for (int i = 0; i < q.size(); i++) begin
            if ($urandom_range(0, 19) == 0)
                send_beat(8'($urandom), 1'b0, 1'b1, 1'($urandom));
            at_end = (i == q.size() - 1);
            send_beat(q[i], at_end && !nv_tail, 1'b0, at_end ? v10 : 1'($urandom));
        end
        if (nv_tail || q.size() == 0)
            send_beat(8'($urandom), 1'b1, 1'b1, v10);
    endtask

    task automatic send_text(input string s, input bit v10, input bit nv_tail);
        logic [7:0] q [$];
        for (int i = 0; i < s.len(); i++)
            q.push_back(8'(s[i]));
        send_header(q, v10, nv_tail);
    endtask

    // hold the input until every pending verdict has come out
    task automatic drain_verdicts();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (verdict_q.size() != 0) @(posedge aclk);
    endtask

    // append a word with random letter case
    task automatic add_word(ref logic [7:0] q [$], input string w);
        logic [7:0] c;
        for (int i = 0; i < w.len(); i++) begin
            c = 8'(w[i]);
            if (c >= 8'h61 && c <= 8'h7A && $urandom_range(0, 1))
                c = c - CASE_FOLD;
            q.push_back(c);
        end
    endtask

    task automatic add_blanks(ref logic [7:0] q [$]);
        repeat ($urandom_range(0, 2))
            q.push_back($urandom_range(0, 1) ? CHAR_SPACE : CHAR_TAB);
    endtask

    // random header: mostly keyword lists, some broken tokens, some pure noise
    task automatic build_header(ref logic [7:0] q [$]);
        int n_tok;
        int kind;
        int cut;
        string w;
        q.delete();
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 12))
                q.push_back(8'($urandom));
            return;
        end
        n_tok = $urandom_range(1, 3);
        for (int t = 0; t < n_tok; t++) begin
            if (t > 0)
                q.push_back(CHAR_COMMA);
            add_blanks(q);
            w = kw_word[$urandom_range(0, KW_NUM - 1)];
            kind = $urandom_range(0, 19);
            if (kind < 14) begin
                add_word(q, w);
            end else if (kind == 14) begin
                // one byte of a keyword replaced
                add_word(q, w);
                q[q.size() - w.len() + $urandom_range(0, w.len() - 1)] = 8'($urandom);
            end else if (kind == 15) begin
                // blank inside the token
                cut = $urandom_range(1, w.len() - 1);
                add_word(q, w.substr(0, cut - 1));
                q.push_back($urandom_range(0, 1) ? CHAR_SPACE : CHAR_TAB);
                add_word(q, w.substr(cut, w.len() - 1));
            end else if (kind == 16) begin
                // keyword cut short or run long
                add_word(q, w.substr(0, $urandom_range(0, w.len() - 2)));
                if ($urandom_range(0, 1))
                    repeat ($urandom_range(1, 12))
                        q.push_back(8'(8'h61 + $urandom_range(0, 25)));
            end else if (kind == 17) begin
                // token near or past the end of the match counter range
                repeat ($urandom_range(14, 20))
                    q.push_back(8'(8'h61 + $urandom_range(0, 25)));
            end else if (kind == 18) begin
                // empty or blanks-only segment
            end else begin
                repeat ($urandom_range(1, 6))
                    q.push_back(8'($urandom));
            end
            add_blanks(q);
        end
        if ($urandom_range(0, 9) == 0)
            q.push_back(CHAR_COMMA);
    endtask

    task automatic test_empty_header();
        send_beat(8'h00, 1'b1, 1'b1, 1'b0);
        send_beat(8'hFF, 1'b1, 1'b1, 1'b1);
    endtask

    task automatic test_keywords();
        send_text("Close", 1'b0, 1'b0);
        send_text("\tkEEP-ALIVE ,", 1'b1, 1'b0);
        send_text(" upgrade\t", 1'b1, 1'b0);
        send_text("upgrade,CLOSE", 1'b0, 1'b1);
    endtask

    task automatic test_bad_tokens();
        send_text("close,keep-alive", 1'b0, 1'b0);
        send_text("clo se", 1'b0, 1'b0);
        send_text(" \t,close", 1'b0, 1'b0);
        send_text(",,", 1'b1, 1'b0);
        send_text("keep-alivekeep-alive", 1'b0, 1'b0);
    endtask

    task automatic test_ignored_beats();
        send_beat(8'hFF, 1'b0, 1'b1, 1'b1);
        send_beat(CHAR_COMMA, 1'b0, 1'b1, 1'b0);
        send_text("upgrade", 1'b0, 1'b0);
    endtask

    task automatic test_random();
        logic [7:0] q [$];
        int start;
        int next_drain;
        start = payload_beats;
        next_drain = start + DRAIN_EVERY;
        while (payload_beats - start < RANDOM_BEATS) begin
            if ($urandom_range(0, 7) == 0)
                calm = ~calm;
            build_header(q);
            send_header(q, 1'($urandom), $urandom_range(0, 9) == 0);
            if (payload_beats >= next_drain) begin
                drain_verdicts();
                next_drain += DRAIN_EVERY;
            end
        end
        calm = 1'b0;
    endtask

    // result side: random stall after each beat taken
    always @(posedge aclk) begin
        if (m_axis_tvalid && m_axis_tready)
            rx_hold = calm ? 0 : $urandom_range(0, 13);
        if (rx_hold > 0) begin
            rx_hold--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // compare each result beat with the oldest pending verdict
    hccu_result_t want;
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (verdict_q.size() == 0) begin
                report_mismatch("result beat with nothing pending", 1, 0);
            end else begin
                want = verdict_q.pop_front();
                if (m_axis_tdata[0] !== want.header_error)
                    report_mismatch("header_error", m_axis_tdata[0], want.header_error);
                if (m_axis_tdata[1] !== want.saw_close)
                    report_mismatch("saw_close", m_axis_tdata[1], want.saw_close);
                if (m_axis_tdata[2] !== want.saw_keep_alive)
                    report_mismatch("saw_keep_alive", m_axis_tdata[2], want.saw_keep_alive);
                if (m_axis_tdata[3] !== want.saw_upgrade)
                    report_mismatch("saw_upgrade", m_axis_tdata[3], want.saw_upgrade);
                if (m_axis_tdata[4] !== want.should_close)
                    report_mismatch("should_close", m_axis_tdata[4], want.should_close);
            end
        end
    end

    // watchdog on cycles where neither side moves a beat
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("http_connection_header_classifier_unit_tb: done, errors");
            $finish;
        end
    end

    // test sequence
    initial begin
        clear_segment();
        found_kw   = '0;
        err_sticky = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_empty_header();
        test_keywords();
        test_bad_tokens();
        test_ignored_beats();
        test_random();
        s_axis_tvalid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0)
            $display("http_connection_header_classifier_unit_tb: done, clean");
        else
            $display("http_connection_header_classifier_unit_tb: done, errors");
        $finish;
    end

endmodule
